// File: design/glv_pkg.sv
// Shared types and constants for the grid line-of-sight visibility block.
// No dependencies; used by the top level and the testbench.
package glv_pkg;

  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int MAX_RANGE        = 32;
  localparam int TOP_LEVEL        = 7;
  localparam int WORD_BITS        = 32;

  localparam int LEVEL_W = 3;
  localparam int RANGE_W = 6;
  localparam int COORD_W = 12;
  localparam int ERR_W   = 10;
  localparam int DIM_W   = 11;
  localparam int CFG_W   = 9;

  localparam logic [CFG_W-1:0] RESET_DIM = 9'd256;

  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_FRAME = 3'd1,
    MODE_CAST  = 3'd2,
    MODE_WORD  = 3'd3,
    MODE_QUERY = 3'd4
  } mode_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_e;

  localparam logic [1:0] SIGHT_HIDDEN  = 2'd0;
  localparam logic [1:0] SIGHT_FOG     = 2'd1;
  localparam logic [1:0] SIGHT_VISIBLE = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               obst;
    logic [1:0]         vis;
  } cell_t;

endpackage

// File: design/glv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module glv_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/grid_line_of_sight_visibility.sv
// Grid line-of-sight visibility map, top level.
// Depends on glv_pkg and glv_ram.
//
// Every cell (level, obstacle flag, visibility) lives in one RAM word, so all
// work goes through that RAM. After reset a clearing pass writes every entry
// (MAX_WIDTH*MAX_HEIGHT, 65536 by default) before the first beat is taken;
// configuration writes are taken at any time. One beat is worked at a time:
// load reads the cell and writes it back with the new level and obstacle flag,
// query reads the cell and captures its state, and a cell off the grid (load,
// cast, query) or an unknown mode goes straight to finish. Read word reads and
// captures each bit in turn, begin frame sweeps the whole RAM, and a cast sets
// up each ray, then reads each cell and writes it back before the ray steps,
// with one more check where a ray ends without hitting a blocker; about 4*(2R+1)
// rays of up to about 1.42R+1 cells, then finish. The block returns to idle
// before the next beat is taken. A finished result waits in an output register
// while the next beat is taken; finish stalls while that register is full.
module grid_line_of_sight_visibility #(
  parameter int MAX_WIDTH  = glv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = glv_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [glv_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  mode_i,
  input  logic [7:0]                  cell_x_i,
  input  logic [7:0]                  cell_y_i,
  input  logic [glv_pkg::LEVEL_W-1:0] terrain_level_i,
  input  logic                        obstacle_i,
  input  logic [glv_pkg::RANGE_W-1:0] range_cells_i,
  input  logic [glv_pkg::LEVEL_W-1:0] viewer_level_i,
  input  logic [10:0]                 word_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [glv_pkg::WORD_BITS-1:0] vis_word_o,
  output logic [1:0]                  cell_state_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = glv_pkg::COORD_W;
  localparam int DW    = glv_pkg::DIM_W;
  localparam int RW    = glv_pkg::RANGE_W;
  localparam int LW    = glv_pkg::LEVEL_W;
  localparam int EW    = glv_pkg::ERR_W;
  localparam int BW    = $clog2(glv_pkg::WORD_BITS);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_LOAD_RD  = 4'd2;
  localparam logic [3:0] S_LOAD_WR  = 4'd3;
  localparam logic [3:0] S_FRAME    = 4'd4;
  localparam logic [3:0] S_RAY_INIT = 4'd5;
  localparam logic [3:0] S_RAY_CHK  = 4'd6;
  localparam logic [3:0] S_RAY_UPD  = 4'd7;
  localparam logic [3:0] S_WORD_RD  = 4'd8;
  localparam logic [3:0] S_WORD_CAP = 4'd9;
  localparam logic [3:0] S_QRY_RD   = 4'd10;
  localparam logic [3:0] S_QRY_CAP  = 4'd11;
  localparam logic [3:0] S_FINISH   = 4'd12;

  // control
  logic [3:0]          state_q, state_d;
  logic [AW:0]         cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [glv_pkg::CFG_W-1:0] width_q, width_d, height_q, height_d;

  // payload
  logic [7:0]          cx_q, cx_d;
  logic [7:0]          cy_q, cy_d;
  logic [LW-1:0]       lvl_q, lvl_d, viewer_q, viewer_d;
  logic                obst_q, obst_d;
  logic [RW-1:0]       r_q, r_d;
  logic [10:0]         widx_q, widx_d;
  logic [2*RW-1:0]     rsq_q, rsq_d;
  logic [AW-1:0]       src_idx_q, src_idx_d, cur_idx_q, cur_idx_d;
  logic [1:0]          side_q, side_d;
  logic [RW:0]         ray_i_q, ray_i_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic                xi_q, xi_d, yi_q, yi_d;
  logic [RW:0]         dx2_q, dx2_d, dy2_q, dy2_d;
  logic signed [EW-1:0] err_q, err_d;
  logic [RW:0]         n_q, n_d;
  logic [BW-1:0]       bit_q, bit_d;
  logic                word_ok_q, word_ok_d;
  logic [glv_pkg::WORD_BITS-1:0] res_word_q, res_word_d, vis_word_q, vis_word_d;
  logic [1:0]          res_state_q, res_state_d, cell_state_q, cell_state_d;

  // RAM
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  glv_pkg::cell_t      ram_wdata, ram_rdata;

  // effective geometry
  logic [DW-1:0]       w_eff, h_eff;
  logic [2*DW-1:0]     total;
  logic                in_fire, in_grid;
  logic [DW+8:0]       acc_idx;
  logic [RW-1:0]       r_sat;

  // ray helpers
  logic signed [RW+1:0] rs, off, ddx, ddy;
  logic [RW:0]          adx, ady;
  logic signed [CW-1:0] ox, oy;
  logic [RW:0]          ax, ay;
  logic [2*RW+2:0]      dist_sq;
  logic                 oob, ray_done;
  logic [15:0]          word_cell;

  glv_ram #(
    .WIDTH ($bits(glv_pkg::cell_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (width_q == '0) begin
      w_eff = DW'(1);
    end else if ({2'b00, width_q} > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = {2'b00, width_q};
    end
    if (height_q == '0) begin
      h_eff = DW'(1);
    end else if ({2'b00, height_q} > DW'(MAX_HEIGHT)) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = {2'b00, height_q};
    end
  end

  assign total      = (2*DW)'(w_eff) * (2*DW)'(h_eff);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_grid    = ({3'b000, cell_x_i} < w_eff) && ({3'b000, cell_y_i} < h_eff);
  assign acc_idx    = (DW+9)'(cell_x_i) + (DW+9)'(cell_y_i) * (DW+9)'(w_eff);
  assign r_sat      = (range_cells_i > RW'(glv_pkg::MAX_RANGE)) ?
                      RW'(glv_pkg::MAX_RANGE) : range_cells_i;

  // ray setup
  always_comb begin
    rs  = $signed({2'b00, r_q});
    off = $signed({1'b0, ray_i_q}) - rs;
    unique case (side_q)
      2'd0: begin
        ddx = off;
        ddy = -rs;
      end
      2'd1: begin
        ddx = off;
        ddy = rs;
      end
      2'd2: begin
        ddx = -rs;
        ddy = off;
      end
      default: begin
        ddx = rs;
        ddy = off;
      end
    endcase
    adx = ddx[RW+1] ? (RW+1)'(-ddx) : (RW+1)'(ddx);
    ady = ddy[RW+1] ? (RW+1)'(-ddy) : (RW+1)'(ddy);
  end

  // per-cell checks
  always_comb begin
    ox      = x_q - $signed({4'b0000, cx_q});
    oy      = y_q - $signed({4'b0000, cy_q});
    ax      = ox[CW-1] ? (RW+1)'(-ox) : (RW+1)'(ox);
    ay      = oy[CW-1] ? (RW+1)'(-oy) : (RW+1)'(oy);
    dist_sq = (2*RW+3)'(ax) * (2*RW+3)'(ax) + (2*RW+3)'(ay) * (2*RW+3)'(ay);
    oob     = x_q[CW-1] || (x_q >= $signed({1'b0, w_eff})) ||
              y_q[CW-1] || (y_q >= $signed({1'b0, h_eff}));
  end

  assign word_cell = {widx_q, bit_q};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    width_d      = width_q;
    height_d     = height_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    lvl_d        = lvl_q;
    viewer_d     = viewer_q;
    obst_d       = obst_q;
    r_d          = r_q;
    widx_d       = widx_q;
    rsq_d        = rsq_q;
    src_idx_d    = src_idx_q;
    cur_idx_d    = cur_idx_q;
    side_d       = side_q;
    ray_i_d      = ray_i_q;
    x_d          = x_q;
    y_d          = y_q;
    xi_d         = xi_q;
    yi_d         = yi_q;
    dx2_d        = dx2_q;
    dy2_d        = dy2_q;
    err_d        = err_q;
    n_d          = n_q;
    bit_d        = bit_q;
    word_ok_d    = word_ok_q;
    res_word_d   = res_word_q;
    res_state_d  = res_state_q;
    vis_word_d   = vis_word_q;
    cell_state_d = cell_state_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_idx_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = cur_idx_q;
    ray_done     = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        glv_pkg::CFG_WIDTH:  width_d  = cfg_data_i;
        glv_pkg::CFG_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = '0;
        if (cnt_q == (AW+1)'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cx_d        = cell_x_i;
          cy_d        = cell_y_i;
          lvl_d       = (terrain_level_i > LW'(glv_pkg::TOP_LEVEL)) ?
                        LW'(glv_pkg::TOP_LEVEL) : terrain_level_i;
          viewer_d    = (viewer_level_i > LW'(glv_pkg::TOP_LEVEL)) ?
                        LW'(glv_pkg::TOP_LEVEL) : viewer_level_i;
          obst_d      = obstacle_i;
          r_d         = r_sat;
          rsq_d       = (2*RW)'(r_sat) * (2*RW)'(r_sat);
          widx_d      = word_index_i;
          src_idx_d   = AW'(acc_idx);
          cur_idx_d   = AW'(acc_idx);
          cnt_d       = '0;
          side_d      = '0;
          ray_i_d     = '0;
          bit_d       = '0;
          res_word_d  = '0;
          res_state_d = glv_pkg::SIGHT_HIDDEN;
          unique case (mode_i)
            glv_pkg::MODE_LOAD:  state_d = in_grid ? S_LOAD_RD : S_FINISH;
            glv_pkg::MODE_FRAME: state_d = S_FRAME;
            glv_pkg::MODE_CAST:  state_d = in_grid ? S_RAY_INIT : S_FINISH;
            glv_pkg::MODE_WORD:  state_d = S_WORD_RD;
            glv_pkg::MODE_QUERY: state_d = in_grid ? S_QRY_RD : S_FINISH;
            default:             state_d = S_FINISH;
          endcase
        end
      end
      S_LOAD_RD: begin
        state_d = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        ram_we          = 1'b1;
        ram_wdata.level = lvl_q;
        ram_wdata.obst  = obst_q;
        ram_wdata.vis   = ram_rdata.vis;
        state_d         = S_FINISH;
      end
      S_FRAME: begin
        // read entry cnt while writing back entry cnt-1
        ram_raddr = cnt_q[AW-1:0];
        ram_waddr = AW'(cnt_q - 1'b1);
        ram_wdata.vis = glv_pkg::SIGHT_FOG;
        if (cnt_q != '0 && ram_rdata.vis == glv_pkg::SIGHT_VISIBLE) begin
          ram_we = 1'b1;
        end
        if (cnt_q == (AW+1)'(DEPTH)) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_RAY_INIT: begin
        x_d       = $signed({4'b0000, cx_q});
        y_d       = $signed({4'b0000, cy_q});
        xi_d      = !ddx[RW+1] && (ddx != '0);
        yi_d      = !ddy[RW+1] && (ddy != '0);
        dx2_d     = (RW+1)'({adx, 1'b0});
        dy2_d     = (RW+1)'({ady, 1'b0});
        err_d     = $signed(EW'(adx)) - $signed(EW'(ady));
        n_d       = (RW+1)'(adx + ady + 1'b1);
        cur_idx_d = src_idx_q;
        state_d   = S_RAY_CHK;
      end
      S_RAY_CHK: begin
        if (n_q == '0 || oob || dist_sq > (2*RW+3)'(rsq_q)) begin
          ray_done = 1'b1;
        end else begin
          state_d = S_RAY_UPD;
        end
      end
      S_RAY_UPD: begin
        ram_we        = 1'b1;
        ram_wdata.vis = glv_pkg::SIGHT_VISIBLE;
        if (ram_rdata.obst || ram_rdata.level > viewer_q) begin
          ray_done = 1'b1;
        end else begin
          n_d     = n_q - 1'b1;
          state_d = S_RAY_CHK;
          if (err_q > 0) begin
            x_d       = xi_q ? x_q + 1'b1 : x_q - 1'b1;
            err_d     = err_q - $signed(EW'(dy2_q));
            cur_idx_d = xi_q ? cur_idx_q + 1'b1 : cur_idx_q - 1'b1;
          end else begin
            y_d       = yi_q ? y_q + 1'b1 : y_q - 1'b1;
            err_d     = err_q + $signed(EW'(dx2_q));
            cur_idx_d = yi_q ? cur_idx_q + AW'(w_eff) : cur_idx_q - AW'(w_eff);
          end
        end
      end
      S_WORD_RD: begin
        ram_raddr = AW'(word_cell);
        word_ok_d = (2*DW)'(word_cell) < total;
        state_d   = S_WORD_CAP;
      end
      S_WORD_CAP: begin
        if (word_ok_q && ram_rdata.vis == glv_pkg::SIGHT_VISIBLE) begin
          res_word_d[bit_q] = 1'b1;
        end
        if (bit_q == BW'(glv_pkg::WORD_BITS - 1)) begin
          state_d = S_FINISH;
        end else begin
          bit_d   = bit_q + 1'b1;
          state_d = S_WORD_RD;
        end
      end
      S_QRY_RD: begin
        state_d = S_QRY_CAP;
      end
      S_QRY_CAP: begin
        res_state_d = ram_rdata.vis;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          vis_word_d   = res_word_q;
          cell_state_d = res_state_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ray_done) begin
      state_d = S_RAY_INIT;
      if (ray_i_q == {r_q, 1'b0}) begin
        ray_i_d = '0;
        if (side_q == 2'd3) begin
          state_d = S_FINISH;
        end else begin
          side_d = side_q + 1'b1;
        end
      end else begin
        ray_i_d = ray_i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      width_q     <= glv_pkg::RESET_DIM;
      height_q    <= glv_pkg::RESET_DIM;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      width_q     <= width_d;
      height_q    <= height_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q         <= cx_d;
    cy_q         <= cy_d;
    lvl_q        <= lvl_d;
    viewer_q     <= viewer_d;
    obst_q       <= obst_d;
    r_q          <= r_d;
    widx_q       <= widx_d;
    rsq_q        <= rsq_d;
    src_idx_q    <= src_idx_d;
    cur_idx_q    <= cur_idx_d;
    side_q       <= side_d;
    ray_i_q      <= ray_i_d;
    x_q          <= x_d;
    y_q          <= y_d;
    xi_q         <= xi_d;
    yi_q         <= yi_d;
    dx2_q        <= dx2_d;
    dy2_q        <= dy2_d;
    err_q        <= err_d;
    n_q          <= n_d;
    bit_q        <= bit_d;
    word_ok_q    <= word_ok_d;
    res_word_q   <= res_word_d;
    res_state_q  <= res_state_d;
    vis_word_q   <= vis_word_d;
    cell_state_q <= cell_state_d;
  end

  assign out_valid_o  = out_valid_q;
  assign vis_word_o   = vis_word_q;
  assign cell_state_o = cell_state_q;

endmodule

// File: bench/grid_line_of_sight_visibility_tb.sv
// Testbench for grid_line_of_sight_visibility: directed and random beats, checked
// against a behavioral model of the cell grid held in this file.
// Depends on glv_pkg and the design sources.
module grid_line_of_sight_visibility_tb;

  localparam int GRID_CELLS  = glv_pkg::DEF_MAX_WIDTH * glv_pkg::DEF_MAX_HEIGHT;
  localparam int STALL_LIMIT = 300000;
  localparam int HOLD_LEN    = 400;
  localparam int DRAIN_WAIT  = 20;
  localparam logic [2:0] MODE_BAD_LO  = 3'd5;
  localparam logic [2:0] MODE_BAD_MID = 3'd6;
  localparam logic [2:0] MODE_BAD_HI  = 3'd7;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [2:0]  lvl;
    logic        obst;
    logic [5:0]  rng;
    logic [2:0]  view;
    logic [10:0] widx;
  } beat_t;

  typedef struct {
    logic [31:0] word;
    logic [1:0]  state;
  } answer_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [8:0]  cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [2:0]  mode_i;
  logic [7:0]  cell_x_i, cell_y_i;
  logic [2:0]  terrain_level_i;
  logic        obstacle_i;
  logic [5:0]  range_cells_i;
  logic [2:0]  viewer_level_i;
  logic [10:0] word_index_i;
  logic        out_valid_o, out_ready_i;
  logic [31:0] vis_word_o;
  logic [1:0]  cell_state_o;

  grid_line_of_sight_visibility dut (.*);

  // model state
  logic [2:0] level_mem [GRID_CELLS];
  logic       block_mem [GRID_CELLS];
  logic [1:0] sight_mem [GRID_CELLS];
  logic [8:0] width_reg, height_reg;

  answer_t answers_q[$];
  int n_sent, n_checked, n_errors, n_casts, n_frames, idle_cycles;
  int burst_left, pat_left, hold_cycles;
  bit pat_choppy, pressure_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int clamp_dim(logic [8:0] v, int top);
    if (v < 1) return 1;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic void walk_ray(int sx, int sy, int ex, int ey, int r, int viewer);
    int w, h, x, y, dx, dy, xi, yi, err, n, rsq, idx, ox, oy;
    w = clamp_dim(width_reg, glv_pkg::DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, glv_pkg::DEF_MAX_HEIGHT);
    x = sx; y = sy;
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    xi = (ex > sx) ? 1 : -1;
    yi = (ey > sy) ? 1 : -1;
    err = dx - dy;
    n = 1 + dx + dy;
    rsq = r * r;
    dx *= 2;
    dy *= 2;
    for (; n > 0; n--) begin
      if (x < 0 || x >= w || y < 0 || y >= h) break;
      idx = x + y * w;
      ox = x - sx;
      oy = y - sy;
      if (ox * ox + oy * oy > rsq) break;
      sight_mem[idx] = glv_pkg::SIGHT_VISIBLE;
      if (block_mem[idx]) break;
      if (int'(level_mem[idx]) > viewer) break;
      if (err > 0) begin
        x += xi;
        err -= dy;
      end else begin
        y += yi;
        err += dx;
      end
    end
  endfunction

  function automatic answer_t predict_visibility(beat_t b);
    answer_t a;
    int w, h, x, y, r, v, i, total, cell_n;
    a.word = '0;
    a.state = glv_pkg::SIGHT_HIDDEN;
    w = clamp_dim(width_reg, glv_pkg::DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, glv_pkg::DEF_MAX_HEIGHT);
    x = b.x;
    y = b.y;
    r = (b.rng > glv_pkg::MAX_RANGE) ? glv_pkg::MAX_RANGE : int'(b.rng);
    v = (b.view > glv_pkg::TOP_LEVEL) ? glv_pkg::TOP_LEVEL : int'(b.view);
    case (b.mode)
      glv_pkg::MODE_LOAD: if (x < w && y < h) begin
        level_mem[x + y * w] = b.lvl;
        block_mem[x + y * w] = b.obst;
      end
      glv_pkg::MODE_FRAME: for (i = 0; i < GRID_CELLS; i++)
        if (sight_mem[i] == glv_pkg::SIGHT_VISIBLE) sight_mem[i] = glv_pkg::SIGHT_FOG;
      glv_pkg::MODE_CAST: if (x < w && y < h) begin
        for (i = x - r; i <= x + r; i++) begin
          walk_ray(x, y, i, y - r, r, v);
          walk_ray(x, y, i, y + r, r, v);
        end
        for (i = y - r; i <= y + r; i++) begin
          walk_ray(x, y, x - r, i, r, v);
          walk_ray(x, y, x + r, i, r, v);
        end
      end
      glv_pkg::MODE_WORD: begin
        total = w * h;
        for (i = 0; i < glv_pkg::WORD_BITS; i++) begin
          cell_n = int'(b.widx) * glv_pkg::WORD_BITS + i;
          if (cell_n < total && sight_mem[cell_n] == glv_pkg::SIGHT_VISIBLE)
            a.word[i] = 1'b1;
        end
      end
      glv_pkg::MODE_QUERY: if (x < w && y < h) a.state = sight_mem[x + y * w];
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_beat(beat_t b);
    int gap;
    mode_i <= b.mode; cell_x_i <= b.x; cell_y_i <= b.y;
    terrain_level_i <= b.lvl; obstacle_i <= b.obst; range_cells_i <= b.rng;
    viewer_level_i <= b.view; word_index_i <= b.widx;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    answers_q.push_back(predict_visibility(b));
    n_sent++;
    if (b.mode == glv_pkg::MODE_CAST) n_casts++;
    if (b.mode == glv_pkg::MODE_FRAME) n_frames++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 10) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(glv_pkg::cfg_e idx, int val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == glv_pkg::CFG_WIDTH) width_reg = val[8:0];
    else height_reg = val[8:0];
    @(posedge clk_i);
  endtask

  function automatic beat_t mk(logic [2:0] m, int x, int y, int lvl = 0, int obst = 0,
                               int rng = 0, int view = 0, int widx = 0);
    beat_t b;
    b.mode = m; b.x = 8'(x); b.y = 8'(y); b.lvl = 3'(lvl); b.obst = 1'(obst);
    b.rng = 6'(rng); b.view = 3'(view); b.widx = 11'(widx);
    return b;
  endfunction

  function automatic beat_t rand_beat(int w, int h);
    beat_t b;
    int pick, words;
    words = (w * h + glv_pkg::WORD_BITS - 1) / glv_pkg::WORD_BITS;
    b.x = 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, w - 1) :
             $urandom_range(0, 255));
    b.y = 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, h - 1) :
             $urandom_range(0, 255));
    b.lvl = 3'($urandom_range(0, 7));
    b.obst = ($urandom_range(0, 99) < 30);
    b.rng = 6'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 63));
    b.view = 3'($urandom_range(0, 7));
    b.widx = 11'(($urandom_range(0, 4) != 0) ? $urandom_range(0, words) :
                 $urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 35) b.mode = glv_pkg::MODE_LOAD;
    else if (pick < 52) b.mode = glv_pkg::MODE_CAST;
    else if (pick < 67) b.mode = glv_pkg::MODE_WORD;
    else if (pick < 92) b.mode = glv_pkg::MODE_QUERY;
    else if (pick < 98 || n_frames >= 4) b.mode = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
    else b.mode = glv_pkg::MODE_FRAME;
    return b;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answers_q.size() == 0) begin
        $display("%0t unexpected beat: word %h state %0d", $time, vis_word_o, cell_state_o);
        n_errors++;
      end else begin
        answer_t a;
        a = answers_q.pop_front();
        n_checked++;
        if (vis_word_o !== a.word) begin
          $display("%0t vis_word expected %h actual %h", $time, a.word, vis_word_o);
          n_errors++;
        end
        if (cell_state_o !== a.state) begin
          $display("%0t cell_state expected %0d actual %0d", $time, a.state, cell_state_o);
          n_errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (pressure_on && hold_cycles < HOLD_LEN) begin
      out_ready_i <= 1'b0;
      hold_cycles++;
    end else begin
      if (pat_left == 0) begin
        pat_choppy = $urandom_range(0, 1);
        pat_left = $urandom_range(20, 150);
      end
      pat_left--;
      out_ready_i <= pat_choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_after_reset();
    send_beat(mk(glv_pkg::MODE_QUERY, 0, 0));
    send_beat(mk(glv_pkg::MODE_WORD, 0, 0, 0, 0, 0, 0, 0));
    send_beat(mk(glv_pkg::MODE_QUERY, 255, 255));
  endtask

  task automatic test_directed();
    send_beat(mk(glv_pkg::MODE_LOAD, 255, 255, 7, 1));
    send_beat(mk(glv_pkg::MODE_LOAD, 131, 128, 5, 0));
    send_beat(mk(glv_pkg::MODE_LOAD, 128, 125, 0, 1));
    send_beat(mk(glv_pkg::MODE_CAST, 128, 128, 0, 0, 0, 0));
    send_beat(mk(glv_pkg::MODE_QUERY, 128, 128));
    send_beat(mk(glv_pkg::MODE_WORD, 0, 0, 0, 0, 0, 0, 1028));
    send_beat(mk(glv_pkg::MODE_CAST, 128, 128, 0, 0, 6, 3));
    send_beat(mk(glv_pkg::MODE_CAST, 250, 250, 0, 0, 63, 7));
    send_beat(mk(glv_pkg::MODE_QUERY, 255, 255));
    send_beat(mk(glv_pkg::MODE_WORD, 0, 0, 0, 0, 0, 0, 2047));
    send_beat(mk(glv_pkg::MODE_FRAME, 0, 0));
    send_beat(mk(glv_pkg::MODE_QUERY, 128, 128));
    send_beat(mk(glv_pkg::MODE_QUERY, 132, 128));
    send_beat(mk(MODE_BAD_LO, 255, 255, 7, 1, 63, 7, 2047));
    send_beat(mk(MODE_BAD_HI, 128, 128, 7, 1, 63, 7, 1028));
    send_beat(mk(MODE_BAD_MID, 0, 0));
    send_beat(mk(glv_pkg::MODE_QUERY, 128, 128));
  endtask

  task automatic test_config_extremes();
    cfg_write(glv_pkg::CFG_WIDTH, 0);
    cfg_write(glv_pkg::CFG_HEIGHT, 511);
    send_beat(mk(glv_pkg::MODE_LOAD, 0, 3, 6, 0));
    send_beat(mk(glv_pkg::MODE_LOAD, 1, 3, 0, 1));
    send_beat(mk(glv_pkg::MODE_CAST, 0, 5, 0, 0, 4, 2));
    send_beat(mk(glv_pkg::MODE_CAST, 3, 5, 0, 0, 4, 2));
    send_beat(mk(glv_pkg::MODE_QUERY, 0, 2));
    send_beat(mk(glv_pkg::MODE_WORD, 0, 0, 0, 0, 0, 0, 0));
    cfg_write(glv_pkg::CFG_WIDTH, 256);
    cfg_write(glv_pkg::CFG_HEIGHT, 1);
    send_beat(mk(glv_pkg::MODE_CAST, 200, 0, 0, 0, 5, 0));
    send_beat(mk(glv_pkg::MODE_QUERY, 200, 1));
    send_beat(mk(glv_pkg::MODE_WORD, 0, 0, 0, 0, 0, 0, 6));
    cfg_write(glv_pkg::CFG_WIDTH, 511);
    cfg_write(glv_pkg::CFG_HEIGHT, 0);
    send_beat(mk(glv_pkg::MODE_WORD, 0, 0, 0, 0, 0, 0, 8));
  endtask

  task automatic run_random_phase(int w, int h, int count);
    cfg_write(glv_pkg::CFG_WIDTH, w);
    cfg_write(glv_pkg::CFG_HEIGHT, h);
    repeat (count)
      send_beat(rand_beat(clamp_dim(width_reg, glv_pkg::DEF_MAX_WIDTH),
                          clamp_dim(height_reg, glv_pkg::DEF_MAX_HEIGHT)));
  endtask

  task automatic test_random();
    run_random_phase(16, 16, 30);
    run_random_phase(40, 7, 25);
    run_random_phase(300, 9, 25);
    run_random_phase($urandom_range(1, 24), $urandom_range(1, 24), 20);
  endtask

  task automatic test_backpressure();
    wait_idle();
    pressure_on = 1'b1;
    @(posedge clk_i);
    repeat (8) send_beat(mk(glv_pkg::MODE_QUERY, $urandom_range(0, 15), $urandom_range(0, 15)));
    while (hold_cycles < HOLD_LEN) @(posedge clk_i);
    pressure_on = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = 1'b0; cfg_data_i = '0;
    in_valid_i = 1'b0; out_ready_i = 1'b0;
    mode_i = '0; cell_x_i = '0; cell_y_i = '0; terrain_level_i = '0; obstacle_i = 1'b0;
    range_cells_i = '0; viewer_level_i = '0; word_index_i = '0;
    for (int i = 0; i < GRID_CELLS; i++) begin
      level_mem[i] = '0;
      block_mem[i] = 1'b0;
      sight_mem[i] = glv_pkg::SIGHT_HIDDEN;
    end
    width_reg = glv_pkg::RESET_DIM;
    height_reg = glv_pkg::RESET_DIM;
    burst_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    wait_idle();
    $display("Covered %0d beats (%0d casts, %0d frame fades), %0d results checked,",
             n_sent, n_casts, n_frames, n_checked);
    $display("grid sizes from clamped extremes to small maps, with output back-pressure.");
    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
